// File: src/cisd_pkg.sv
`default_nettype none

package cisd_pkg;

    localparam int unsigned ArgW    = 64;
    localparam int unsigned CfgLenW = 16;
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned ApbAddrW = 3;
    localparam logic [CfgLenW-1:0] MaxStringLenReset = 16'd64;

    // Event codes
    localparam logic [2:0] EV_PENDING     = 3'd0;
    localparam logic [2:0] EV_HEAD_DONE   = 3'd1;
    localparam logic [2:0] EV_PAYLOAD     = 3'd2;
    localparam logic [2:0] EV_TRUNCATED   = 3'd3;
    localparam logic [2:0] EV_UNSUPPORTED = 3'd4;

    // Decoder phases
    localparam logic [1:0] PH_INITIAL = 2'd0;
    localparam logic [1:0] PH_HEAD    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Additional info codes
    localparam logic [4:0] AI_MASK   = 5'h1f;
    localparam logic [4:0] AI_ONE    = 5'd24;
    localparam logic [4:0] AI_TWO    = 5'd25;
    localparam logic [4:0] AI_FOUR   = 5'd26;
    localparam logic [4:0] AI_EIGHT  = 5'd27;

    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_BYTES = 3'd2;
    localparam logic [2:0] MT_TEXT  = 3'd3;

    // Register index of max_string_len
    localparam logic REG_MAX_STRING_LEN = 1'b0;

    typedef struct packed {
        logic [1:0]     phase;
        logic [3:0]     head_left;
        logic [ArgW-1:0] arg_accum;
        logic [2:0]     held_major;
        logic [ArgW-1:0] payload_left;
        logic           dropping;
    } cisd_state_t;

    typedef struct packed {
        logic [2:0]             event_res;
        logic [2:0]             major_type;
        logic [ArgW-1:0]        argument;
        logic signed [ArgW-1:0] int_value;
        logic                   int_out_of_range;
        logic                   string_too_long;
        logic [7:0]             payload_byte;
        logic                   payload_last;
    } cisd_result_t;

endpackage

`default_nettype wire

// File: src/cisd_cfg.sv
`default_nettype none

module cisd_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cisd_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [cisd_pkg::ApbDataW-1:0]   pwdata,
    output logic      [cisd_pkg::ApbDataW-1:0]   prdata,
    output logic                                 pready,
    output logic      [cisd_pkg::CfgLenW-1:0]    max_string_len
);
    import cisd_pkg::*;

    logic [CfgLenW-1:0] max_len_reg;
    logic [CfgLenW-1:0] max_len_next;
    logic               reg_sel;

    // Word index is the address above the byte offset
    assign reg_sel = paddr[ApbAddrW-1];

    always_comb
    begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && (reg_sel == REG_MAX_STRING_LEN))
        begin
            max_len_next = pwdata[CfgLenW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MaxStringLenReset;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_MAX_STRING_LEN)
        begin
            prdata = {{(ApbDataW-CfgLenW){1'b0}}, max_len_reg};
        end
    end

    assign pready         = 1'b1;
    assign max_string_len = max_len_reg;

endmodule

`default_nettype wire

// File: src/cisd_step.sv
`default_nettype none

module cisd_step
(
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        end_of_data,
    input  wire logic [cisd_pkg::CfgLenW-1:0] max_string_len,
    input  wire cisd_pkg::cisd_state_t       cur,
    output cisd_pkg::cisd_state_t            nxt,
    output cisd_pkg::cisd_result_t           res
);
    import cisd_pkg::*;

    logic [4:0]      ai;
    logic [3:0]      head_dec;
    logic [ArgW-1:0] accum_shift;
    logic [ArgW-1:0] pay_dec;
    logic            hd_fire;
    logic [ArgW-1:0] hd_arg;
    logic            too_long;

    assign ai          = data_byte[4:0] & AI_MASK;
    assign head_dec    = cur.head_left - 4'd1;
    assign accum_shift = {cur.arg_accum[ArgW-9:0], data_byte};
    assign pay_dec     = cur.payload_left - {{(ArgW-1){1'b0}}, 1'b1};

    always_comb
    begin
        nxt     = cur;
        res     = '0;
        hd_fire = 1'b0;
        hd_arg  = '0;

        case (cur.phase)
            PH_HEAD:
            begin
                nxt.arg_accum = accum_shift;
                nxt.head_left = head_dec;
                res.major_type = cur.held_major;
                if (head_dec == 4'd0)
                begin
                    hd_fire = 1'b1;
                    hd_arg  = accum_shift;
                end
                else if (end_of_data)
                begin
                    res.event_res = EV_TRUNCATED;
                    nxt.phase     = PH_INITIAL;
                end
            end
            PH_PAYLOAD:
            begin
                nxt.payload_left    = pay_dec;
                res.major_type      = cur.held_major;
                res.string_too_long = cur.dropping;
                if ((pay_dec != '0) && end_of_data)
                begin
                    res.event_res = EV_TRUNCATED;
                    nxt.phase     = PH_INITIAL;
                end
                else
                begin
                    res.event_res    = cur.dropping ? EV_PENDING : EV_PAYLOAD;
                    res.payload_byte = cur.dropping ? 8'd0 : data_byte;
                    res.payload_last = (pay_dec == '0);
                    if (pay_dec == '0)
                    begin
                        nxt.phase = PH_INITIAL;
                    end
                end
            end
            default:
            begin
                // Initial byte; the unused phase code lands here too
                nxt.held_major = data_byte[7:5];
                nxt.phase      = PH_INITIAL;
                if (ai < AI_ONE)
                begin
                    hd_fire = 1'b1;
                    hd_arg  = {{(ArgW-5){1'b0}}, ai};
                end
                else if (ai <= AI_EIGHT)
                begin
                    res.major_type = data_byte[7:5];
                    if (end_of_data)
                    begin
                        res.event_res = EV_TRUNCATED;
                    end
                    else
                    begin
                        nxt.head_left = 4'd1 << ai[1:0];
                        nxt.arg_accum = '0;
                        nxt.phase     = PH_HEAD;
                    end
                end
                else
                begin
                    res.event_res  = EV_UNSUPPORTED;
                    res.major_type = data_byte[7:5];
                    res.argument   = {{(ArgW-5){1'b0}}, ai};
                end
            end
        endcase

        too_long = (hd_arg[ArgW-1:CfgLenW] != '0) || (hd_arg[CfgLenW-1:0] > max_string_len);

        if (hd_fire)
        begin
            res.event_res  = EV_HEAD_DONE;
            res.major_type = nxt.held_major;
            res.argument   = hd_arg;
            nxt.phase      = PH_INITIAL;
            if ((nxt.held_major == MT_UINT) || (nxt.held_major == MT_NINT))
            begin
                if (hd_arg[ArgW-1])
                begin
                    res.int_out_of_range = 1'b1;
                end
                else
                begin
                    res.int_value = (nxt.held_major == MT_UINT) ? hd_arg : ~hd_arg;
                end
            end
            else if ((nxt.held_major == MT_BYTES) || (nxt.held_major == MT_TEXT))
            begin
                res.string_too_long = too_long;
                if (hd_arg != '0)
                begin
                    if (end_of_data)
                    begin
                        res.event_res = EV_TRUNCATED;
                        res.argument  = '0;
                    end
                    else
                    begin
                        nxt.phase        = PH_PAYLOAD;
                        nxt.payload_left = hd_arg;
                        nxt.dropping     = too_long;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/cbor_item_stream_decoder_core.sv
`default_nettype none

// Channel   Handshake           Payload
// input     in_valid/in_ready   data_byte, end_of_data
// output    out_valid/out_ready event_res, major_type, argument, int_value,
//                               int_out_of_range, string_too_long,
//                               payload_byte, payload_last
// config    APB (psel/penable)  max_string_len at byte address 0
//
// One byte per clock sustained while the output is not stalled; each accepted
// byte passes through the input register, then the result register.
// The decode of one byte is a single pass from the input register through
// the head/payload logic into the result register and the decoder state.
// A stall on the output holds both registers; the input register still
// takes a byte while the result register is full but about to drain.
// Reset returns the decoder to expecting an initial byte, max_string_len 64.
module cbor_item_stream_decoder_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             end_of_data,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [2:0]                       event_res,
    output logic      [2:0]                       major_type,
    output logic      [63:0]                      argument,
    output logic signed [63:0]                    int_value,
    output logic                                  int_out_of_range,
    output logic                                  string_too_long,
    output logic      [7:0]                       payload_byte,
    output logic                                  payload_last,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cisd_pkg::ApbAddrW-1:0]    paddr,
    input  wire logic [cisd_pkg::ApbDataW-1:0]    pwdata,
    output logic      [cisd_pkg::ApbDataW-1:0]    prdata,
    output logic                                  pready
);
    import cisd_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               eod_reg;
    cisd_state_t        state_reg;
    cisd_state_t        state_next;
    cisd_result_t       res_reg;
    cisd_result_t       res_next;
    logic               out_valid_reg;
    logic               advance;
    logic [CfgLenW-1:0] max_string_len;

    cisd_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_string_len (max_string_len)
    );

    cisd_step u_step
    (
        .data_byte      (byte_reg),
        .end_of_data    (eod_reg),
        .max_string_len (max_string_len),
        .cur            (state_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    // Move the held byte into the result register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_INITIAL, default: '0};
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            eod_reg  <= end_of_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = res_reg.event_res;
    assign major_type       = res_reg.major_type;
    assign argument         = res_reg.argument;
    assign int_value        = res_reg.int_value;
    assign int_out_of_range = res_reg.int_out_of_range;
    assign string_too_long  = res_reg.string_too_long;
    assign payload_byte     = res_reg.payload_byte;
    assign payload_last     = res_reg.payload_last;

endmodule

`default_nettype wire

// File: bench/tb_cbor_item_stream_decoder_core.sv
`timescale 1ns / 1ps

module tb_cbor_item_stream_decoder_core;

    import cisd_pkg::*;

    localparam int QuietLimit = 1000;
    localparam logic [ApbAddrW-1:0] LenAddr = ApbAddrW'(4 * REG_MAX_STRING_LEN);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    class cbor_event_scoreboard;
        logic [1:0]   phase;
        logic [3:0]   head_left;
        logic [63:0]  arg_acc;
        logic [2:0]   major;
        logic [63:0]  pay_left;
        logic         dropping;
        logic [15:0]  max_len;
        cisd_result_t pending_events[$];
        int           errors;

        function new();
            phase     = PH_INITIAL;
            head_left = 4'd0;
            arg_acc   = 64'd0;
            major     = 3'd0;
            pay_left  = 64'd0;
            dropping  = 1'b0;
            max_len   = MaxStringLenReset;
            errors    = 0;
        endfunction

        function void set_max_len(logic [15:0] v);
            max_len = v;
        endfunction

        // Close out a head and pick the next phase
        function void finish_head(logic [63:0] arg, logic eod, inout cisd_result_t r);
            logic too_long;
            r.event_res  = EV_HEAD_DONE;
            r.major_type = major;
            r.argument   = arg;
            phase        = PH_INITIAL;
            if (major == MT_UINT || major == MT_NINT)
            begin
                if (arg[63])
                    r.int_out_of_range = 1'b1;
                else
                    r.int_value = (major == MT_UINT) ? arg : ~arg;
            end
            else if (major == MT_BYTES || major == MT_TEXT)
            begin
                too_long = arg > {48'd0, max_len};
                r.string_too_long = too_long;
                if (arg != 64'd0)
                begin
                    if (eod)
                    begin
                        r.event_res = EV_TRUNCATED;
                        r.argument  = 64'd0;
                    end
                    else
                    begin
                        phase    = PH_PAYLOAD;
                        pay_left = arg;
                        dropping = too_long;
                    end
                end
            end
        endfunction

        function void decode_byte(logic [7:0] b, logic eod);
            cisd_result_t r;
            logic [4:0]   ai;
            r  = '0;
            ai = b[4:0] & AI_MASK;
            case (phase)
                PH_HEAD:
                begin
                    arg_acc   = {arg_acc[55:0], b};
                    head_left = head_left - 4'd1;
                    if (head_left == 4'd0)
                        finish_head(arg_acc, eod, r);
                    else
                    begin
                        r.major_type = major;
                        if (eod)
                        begin
                            r.event_res = EV_TRUNCATED;
                            phase       = PH_INITIAL;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_left          = pay_left - 64'd1;
                    r.major_type      = major;
                    r.string_too_long = dropping;
                    if (pay_left != 64'd0 && eod)
                    begin
                        r.event_res = EV_TRUNCATED;
                        phase       = PH_INITIAL;
                    end
                    else
                    begin
                        r.event_res    = dropping ? EV_PENDING : EV_PAYLOAD;
                        r.payload_byte = dropping ? 8'd0 : b;
                        r.payload_last = (pay_left == 64'd0);
                        if (pay_left == 64'd0)
                            phase = PH_INITIAL;
                    end
                end
                default:
                begin
                    major = b[7:5];
                    phase = PH_INITIAL;
                    if (ai < AI_ONE)
                        finish_head({59'd0, ai}, eod, r);
                    else if (ai <= AI_EIGHT)
                    begin
                        r.major_type = major;
                        if (eod)
                            r.event_res = EV_TRUNCATED;
                        else
                        begin
                            head_left = 4'd1 << (ai - AI_ONE);
                            arg_acc   = 64'd0;
                            phase     = PH_HEAD;
                        end
                    end
                    else
                    begin
                        r.event_res  = EV_UNSUPPORTED;
                        r.major_type = major;
                        r.argument   = {59'd0, ai};
                    end
                end
            endcase
            pending_events.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch: expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(cisd_result_t got);
            cisd_result_t want;
            if (pending_events.size() == 0)
            begin
                $display("%0t: result with no byte pending: expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("major_type", want.major_type, got.major_type);
            compare_field("argument", want.argument, got.argument);
            compare_field("int_value", want.int_value, got.int_value);
            compare_field("int_out_of_range", want.int_out_of_range, got.int_out_of_range);
            compare_field("string_too_long", want.string_too_long, got.string_too_long);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_last", want.payload_last, got.payload_last);
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [7:0]          data_byte   = 8'd0;
    logic                end_of_data = 1'b0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [2:0]          event_res;
    logic [2:0]          major_type;
    logic [63:0]         argument;
    logic signed [63:0]  int_value;
    logic                int_out_of_range;
    logic                string_too_long;
    logic [7:0]          payload_byte;
    logic                payload_last;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ApbAddrW-1:0] paddr       = '0;
    logic [ApbDataW-1:0] pwdata      = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    cbor_event_scoreboard sb;
    stream_byte_t         stream_q[$];
    cisd_result_t         seen_result;
    int                   quiet_cycles = 0;
    int                   rx_mode      = 0;
    int                   rx_mode_left = 0;
    int                   rx_hold      = 0;
    logic                 rx_level     = 1'b1;
    logic [1:0]           rx_cycle     = 2'd0;
    logic [15:0]          len_settings[7] = '{16'd0, 16'hffff, 16'd1, 16'd24, 16'd3,
                                              16'd0, 16'd64};

    cbor_item_stream_decoder_core u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .end_of_data      (end_of_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_res        (event_res),
        .major_type       (major_type),
        .argument         (argument),
        .int_value        (int_value),
        .int_out_of_range (int_out_of_range),
        .string_too_long  (string_too_long),
        .payload_byte     (payload_byte),
        .payload_last     (payload_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor both channels and watch for a hung handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.decode_byte(data_byte, end_of_data);
            if (out_valid && out_ready)
            begin
                seen_result = '{event_res, major_type, argument, int_value, int_out_of_range,
                                string_too_long, payload_byte, payload_last};
                sb.check_result(seen_result);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver backpressure: switch between free-running, random, periodic and long stalls
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 2'd1;
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 200);
        end
        else
            rx_mode_left = rx_mode_left - 1;
        if (rx_hold == 0)
        begin
            rx_level = ~rx_level;
            rx_hold  = $urandom_range(1, 10);
        end
        else
            rx_hold = rx_hold - 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 9) < 7);
            2:       out_ready <= (rx_cycle != 2'd0);
            default: out_ready <= rx_level;
        endcase
    end

    function automatic void put(logic [7:0] v, logic last);
        stream_q.push_back('{v, last});
    endfunction

    // Append one CBOR item, mostly well formed, sometimes cut short by end of buffer
    function automatic void add_item(logic [15:0] max_len);
        logic [7:0]  item_q[$];
        logic [63:0] arg;
        int unsigned pick, mt, ai, min_ai, nbytes, cnt, cut, i;
        bit          is_string, huge;
        pick = $urandom_range(0, 99);
        mt = pick < 20 ? 0 : pick < 35 ? 1 : pick < 55 ? 2 : pick < 75 ? 3 :
             pick < 82 ? 6 : pick < 88 ? $urandom_range(4, 5) : 7;
        is_string = (mt == MT_BYTES || mt == MT_TEXT);
        huge = 1'b0;
        nbytes = 0;
        if (is_string)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                arg = 64'($urandom_range(0, 12));
            else if (pick < 75)
            begin
                if (max_len > 16'd80)
                    arg = 64'($urandom_range(0, 40));
                else
                begin
                    cnt = max_len + $urandom_range(0, 2);
                    arg = 64'((cnt == 0) ? 0 : cnt - 1);
                end
            end
            else if (pick < 90)
                arg = 64'($urandom_range(13, 60));
            else
            begin
                huge = 1'b1;
                arg  = {$urandom, $urandom} | 64'h1_0000;
            end
        end
        else
        begin
            arg = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       arg = 64'h7fff_ffff_ffff_ffff;
                1:       arg = 64'h8000_0000_0000_0000;
                2:       arg = '1;
                default: ;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            ai = $urandom_range(28, 31);
        else if (is_string)
        begin
            if (arg < 24 && $urandom_range(0, 1) == 1)
                ai = 32'(arg);
            else
            begin
                min_ai = arg < 64'h100 ? 24 : arg < 64'h1_0000 ? 25 :
                         arg < 64'h1_0000_0000 ? 26 : 27;
                ai = ($urandom_range(0, 1) == 1) ? min_ai : $urandom_range(min_ai, 27);
            end
        end
        else if (pick < 40)
            ai = $urandom_range(0, 23);
        else
            ai = $urandom_range(24, 27);
        if (ai >= 24 && ai <= 27)
        begin
            nbytes = 1 << (ai - 24);
            if (nbytes < 8)
                arg = arg & ((64'd1 << (8 * nbytes)) - 64'd1);
        end
        item_q.push_back({mt[2:0], ai[4:0]});
        for (i = nbytes; i > 0; i--)
            item_q.push_back(arg[8 * (i - 1) +: 8]);
        if (is_string && ai < 28)
        begin
            cnt = huge ? $urandom_range(0, 5) : 32'(arg);
            repeat (cnt) item_q.push_back(8'($urandom_range(0, 255)));
        end
        cut = item_q.size() - 1;
        pick = $urandom_range(0, 99);
        if (huge && ai < 28)
            pick = 0;
        else if (pick >= 10 && pick < 18 && item_q.size() > 1)
            cut = $urandom_range(0, item_q.size() - 2);
        for (i = 0; i <= cut; i++)
            put(item_q[i], (i == cut) && pick < 18);
    endfunction

    function automatic void fill_random(int unsigned count, logic [15:0] max_len);
        while (stream_q.size() < count)
        begin
            if ($urandom_range(0, 99) < 8)
                put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                add_item(max_len);
        end
    endfunction

    // Send the queued bytes in bursts with random gaps in between
    task automatic send_stream();
        stream_byte_t nxt;
        int           burst_left;
        int           gap;
        burst_left = 0;
        while (stream_q.size() != 0)
        begin
            nxt = stream_q.pop_front();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid    <= 1'b1;
            data_byte   <= nxt.value;
            end_of_data <= nxt.last;
            do @(posedge clk); while (!in_ready);
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_max_len(logic [15:0] v);
        logic [ApbDataW-1:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LenAddr;
        pwdata  <= ApbDataW'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_max_len(v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[CfgLenW-1:0] !== v)
        begin
            $display("%0t: max_string_len readback mismatch: expected %h actual %h",
                     $time, v, readback[CfgLenW-1:0]);
            sb.errors++;
        end
    endtask

    initial
    begin
        int i;
        sb = new();
        len_settings[3] = 16'($urandom_range(0, 40));
        len_settings[5] = 16'($urandom_range(0, 65535));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed bytes at the reset length limit
        put(8'h00, 1'b0);                        // uint 0
        put(8'h37, 1'b0);                        // nint -24
        put(8'h3b, 1'b0);                        // nint with 2^63: out of range
        put(8'h80, 1'b0);
        repeat (7) put(8'h00, 1'b0);
        put(8'h60, 1'b0);                        // empty text string
        put(8'h5f, 1'b0);                        // indefinite byte string
        put(8'hff, 1'b0);                        // break
        put(8'hf9, 1'b0);                        // half float bits
        put(8'h3c, 1'b0);
        put(8'h00, 1'b0);
        put(8'h58, 1'b0);                        // 65 bytes, one over limit, cut short
        put(8'h41, 1'b0);
        put(8'h7e, 1'b1);
        put(8'h1a, 1'b0);                        // head cut short
        put(8'h12, 1'b1);
        send_stream();
        drain();

        // Dropped payload, then a payload whose last byte ends the buffer
        program_max_len(16'd2);
        put(8'h43, 1'b0);
        put(8'h11, 1'b0);
        put(8'h22, 1'b0);
        put(8'h33, 1'b0);
        put(8'h42, 1'b0);
        put(8'haa, 1'b0);
        put(8'h55, 1'b1);
        send_stream();
        drain();

        for (i = 0; i < 7; i++)
        begin
            program_max_len(len_settings[i]);
            fill_random(155, len_settings[i]);
            send_stream();
            drain();
        end

        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
